// File: rtl/core/assert_macros.svh
// Assertion macros shared by the deque RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// File: rtl/core/rbd_pkg.sv
// Types, codes and default sizes for the ring buffer deque.
package rbd_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int WORD_BITS_DEF = 32;

    // Operation codes carried in the request kind field
    localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
    localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_BACK   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] push_word;
    } in_item_t;

    typedef struct packed {
        logic [31:0] popped_word;
        logic [1:0]  status;
        logic [4:0]  count;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       wr_back;
        logic       wr_front;
        logic       rd_front;
        logic       rd_back;
        logic [1:0] status;
    } dq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } dq_stat_t;

endpackage

// File: rtl/core/rbd_ctrl.sv
// Deque controller: handshake state machine and operation decode.
`include "assert_macros.svh"

module rbd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        kind,
    output logic              out_valid,
    input  logic              out_ready,
    input  rbd_pkg::dq_stat_t stat,
    output rbd_pkg::dq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_HOLD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign out_valid = (state_reg == S_HOLD);
    // output slot frees up in the same cycle it is drained
    assign in_ready  = (state_reg == S_IDLE) || out_ready;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = in_valid && in_ready;
        cmd.status   = rbd_pkg::ST_OK;
        case (kind)
            rbd_pkg::OP_PUSH_BACK:
            begin
                if (stat.full)
                    cmd.status = rbd_pkg::ST_FULL;
                else
                    cmd.wr_back = cmd.load;
            end
            rbd_pkg::OP_PUSH_FRONT:
            begin
                if (stat.full)
                    cmd.status = rbd_pkg::ST_FULL;
                else
                    cmd.wr_front = cmd.load;
            end
            rbd_pkg::OP_POP_FRONT:
            begin
                if (stat.empty)
                    cmd.status = rbd_pkg::ST_EMPTY;
                else
                    cmd.rd_front = cmd.load;
            end
            rbd_pkg::OP_POP_BACK:
            begin
                if (stat.empty)
                    cmd.status = rbd_pkg::ST_EMPTY;
                else
                    cmd.rd_back = cmd.load;
            end
            default:
            begin
                cmd.status = rbd_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                    state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (out_ready && !cmd.load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `ASSERT_IMPL(a_reject_no_write, cmd.load && (cmd.status != rbd_pkg::ST_OK), !cmd.wr_back && !cmd.wr_front && !cmd.rd_front && !cmd.rd_back)
    `ASSERT_NEXT(a_load_gives_result, cmd.load, out_valid)

endmodule

// File: rtl/core/rbd_datapath.sv
// Deque datapath: ring store, head/tail pointers, fill count, result register.
`include "assert_macros.svh"

module rbd_datapath #(
    parameter int CAPACITY  = rbd_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = rbd_pkg::WORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rbd_pkg::dq_cmd_t   cmd,
    input  logic [31:0]        push_word,
    output rbd_pkg::dq_stat_t  stat,
    output rbd_pkg::out_item_t result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic [WORD_BITS-1:0] mem [CAPACITY];

    logic [IDX_W-1:0]     head_reg;
    logic [IDX_W-1:0]     head_next;
    logic [IDX_W-1:0]     tail_reg;
    logic [IDX_W-1:0]     tail_next;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [1:0]           status_reg;
    logic [4:0]           count_reg;
    logic                 pop_ok_reg;

    logic [IDX_W-1:0]        head_inc;
    logic [IDX_W-1:0]        head_dec;
    logic [IDX_W-1:0]        tail_inc;
    logic [IDX_W-1:0]        tail_dec;
    logic [IDX_W-1:0]        wr_addr;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic                    rd_en;
    logic [WORD_BITS+31:0]   push_ext;
    logic [WORD_BITS+31:0]   pop_ext;
    logic [CNT_W+4:0]        count_ext;
    logic [CNT_W:0]          ptr_sum;

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;

    assign stat.full  = (fill_reg == FULL_CNT);
    assign stat.empty = (fill_reg == '0);

    assign wr_en   = cmd.wr_back || cmd.wr_front;
    assign rd_en   = cmd.rd_front || cmd.rd_back;
    assign wr_addr = cmd.wr_front ? head_dec : tail_reg;
    assign rd_addr = cmd.rd_back ? tail_dec : head_reg;

    // fit the 32-bit request word to the store width
    assign push_ext = {{WORD_BITS{1'b0}}, push_word};

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (cmd.wr_back)
        begin
            tail_next = tail_inc;
            fill_next = fill_reg + 1'b1;
        end
        if (cmd.wr_front)
        begin
            head_next = head_dec;
            fill_next = fill_reg + 1'b1;
        end
        if (cmd.rd_front)
        begin
            head_next = head_inc;
            fill_next = fill_reg - 1'b1;
        end
        if (cmd.rd_back)
        begin
            tail_next = tail_dec;
            fill_next = fill_reg - 1'b1;
        end
    end

    assign count_ext = {5'b0, fill_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // single-port ring store with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= push_ext[WORD_BITS-1:0];
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop_ok_reg <= 1'b0;
        else if (cmd.load)
            pop_ok_reg <= rd_en;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg <= cmd.status;
            count_reg  <= count_ext[4:0];
        end
    end

    assign pop_ext            = {32'b0, rd_data_reg};
    assign result.popped_word = pop_ok_reg ? pop_ext[31:0] : 32'b0;
    assign result.status      = status_reg;
    assign result.count       = count_reg;

    // head + fill must land on tail modulo the capacity
    assign ptr_sum = {1'b0, head_reg} + {1'b0, fill_reg};

    `ASSERT_IMPL(a_fill_bound, 1'b1, fill_reg <= FULL_CNT)
    `ASSERT_IMPL(a_ptr_consistent, 1'b1, (ptr_sum == (CNT_W+1)'(tail_reg)) || (ptr_sum == (CNT_W+1)'(tail_reg) + (CNT_W+1)'(CAPACITY)))
    `ASSERT_NEXT(a_push_grows, wr_en, fill_reg == $past(fill_reg) + 1'b1)

endmodule

// File: rtl/core/ring_buffer_deque.sv
// Ring buffer deque: top level joining the controller and the datapath.
// A result is offered in the cycle after its request is accepted.
// Throughput: one request per cycle; the output register frees in the same
// cycle it is drained, so in_ready only drops while a result is stalled.
// Reset (rst_n low, asynchronous): deque empty, head and tail at zero,
// no result pending. The ring store itself is not cleared.

module ring_buffer_deque #(
    parameter int CAPACITY  = rbd_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = rbd_pkg::WORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rbd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rbd_pkg::out_item_t out_data
);

    // Commands go down to the datapath; full/empty flags come back up.
    rbd_pkg::dq_cmd_t  cmd;
    rbd_pkg::dq_stat_t stat;

    // The controller decodes the request kind against the current
    // full/empty flags: a rejected push or pop still yields a result
    // (status FULL or EMPTY) but issues no store or pointer command.
    rbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (in_data.kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath owns the ring store (one write or one registered read
    // per request), the head/tail pointers, the fill count and the result
    // register that holds status and count until the result is taken.
    rbd_datapath #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .push_word (in_data.push_word),
        .stat      (stat),
        .result    (out_data)
    );

endmodule
